[hdl/tmps_pkg.sv]
// ----------------------------------------------------------------------------
// tmps_pkg
// shared widths, reset values and types of the triangle path sum unit
// ----------------------------------------------------------------------------
package tmps_pkg;

   localparam int VALUE_W      = 10;
   localparam int SUM_W        = 16;
   localparam int ROW_COUNT_W  = 7;
   localparam int DEF_MAX_ROWS = 64;

   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = ROW_COUNT_W'(15);
   localparam logic [SUM_W-1:0]       SUM_MAX         = {SUM_W{1'b1}};

   typedef struct packed {
      logic             shift;
      logic [SUM_W-1:0] sum;
   } chain_ctl_type;

endpackage

[hdl/tmps_req_if.sv]
// ----------------------------------------------------------------------------
// tmps_req_if
// input channel: one triangle entry per transfer
// ----------------------------------------------------------------------------
interface tmps_req_if;
   import tmps_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);

endinterface

[hdl/tmps_rsp_if.sv]
// ----------------------------------------------------------------------------
// tmps_rsp_if
// result channel: greatest path sum of one triangle per transfer
// ----------------------------------------------------------------------------
interface tmps_rsp_if;
   import tmps_pkg::*;

   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] peak_total;

   modport source (output valid, output peak_total, input ready);
   modport sink   (input valid, input peak_total, output ready);

endinterface

[hdl/tmps_cell.sv]
// ----------------------------------------------------------------------------
// tmps_cell
// one stage of the row sum chain: loads the new sum when its position matches
// the current row, otherwise takes the value of its upper neighbor
// ----------------------------------------------------------------------------
module tmps_cell #(
   parameter int IDX   = 0,
   parameter int ROW_W = 6
) (
   input  logic                       clock,
   input  tmps_pkg::chain_ctl_type    ctl_i,
   input  logic [ROW_W-1:0]           row_i,
   input  logic [tmps_pkg::SUM_W-1:0] next_i,
   output logic [tmps_pkg::SUM_W-1:0] val_o
);
   import tmps_pkg::*;

   logic [SUM_W-1:0] val_ff;
   logic [SUM_W-1:0] val_in;

   always_comb begin
      val_in = (row_i == ROW_W'(IDX)) ? ctl_i.sum : next_i;
   end

   always_ff @(posedge clock) begin
      if (ctl_i.shift) begin
         val_ff <= val_in;
      end
   end

   assign val_o = val_ff;

endmodule

[hdl/tmps_head.sv]
// ----------------------------------------------------------------------------
// tmps_head
// position counters, parent selection, saturating add, row maximum and
// result register
// ----------------------------------------------------------------------------
module tmps_head #(
   parameter int MAX_ROWS = tmps_pkg::DEF_MAX_ROWS,
   parameter int ROW_W    = $clog2(MAX_ROWS)
) (
   input  logic                             clock,
   input  logic                             reset,
   tmps_req_if.sink                         req_bus,
   tmps_rsp_if.source                       rsp_bus,
   input  logic [tmps_pkg::ROW_COUNT_W-1:0] row_count_i,
   input  logic [tmps_pkg::SUM_W-1:0]       above_i,
   output tmps_pkg::chain_ctl_type          ctl_o,
   output logic [ROW_W-1:0]                 row_o
);
   import tmps_pkg::*;

   localparam int CMP_W = (ROW_W + 1 > ROW_COUNT_W) ? ROW_W + 1 : ROW_COUNT_W;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] col_ff, col_in;
   logic [SUM_W-1:0] left_ff, left_in;
   logic [SUM_W-1:0] max_ff, max_in;
   logic             out_valid_ff, out_valid_in;
   logic [SUM_W-1:0] out_data_ff, out_data_in;

   logic             accept;
   logic             first_col;
   logic             last_col;
   logic             last_row;
   logic [SUM_W-1:0] parent;
   logic [SUM_W:0]   sum_wide;
   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] max_new;
   logic [CMP_W-1:0] next_row_ext;

   assign req_bus.ready = !out_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      first_col = (col_ff == '0);
      last_col  = (col_ff == row_ff);
      if (first_col) begin
         parent = above_i;
      end else if (last_col) begin
         parent = left_ff;
      end else begin
         parent = (left_ff > above_i) ? left_ff : above_i;
      end
      sum_wide = {1'b0, parent} + (SUM_W + 1)'(req_bus.value);
      if (row_ff == '0) begin
         sum = SUM_W'(req_bus.value);
      end else if (sum_wide[SUM_W]) begin
         sum = SUM_MAX;
      end else begin
         sum = sum_wide[SUM_W-1:0];
      end
      max_new      = (first_col || sum > max_ff) ? sum : max_ff;
      next_row_ext = CMP_W'(row_ff) + CMP_W'(1);
      last_row     = (next_row_ext >= CMP_W'(row_count_i))
                  || (row_ff == ROW_W'(MAX_ROWS - 1));
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      left_in      = left_ff;
      max_in       = max_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (accept) begin
         max_in = max_new;
         if (row_ff != '0) begin
            left_in = above_i;
         end
         if (last_col) begin
            col_in  = '0;
            left_in = '0;
            if (last_row) begin
               row_in       = '0;
               max_in       = '0;
               out_valid_in = 1'b1;
               out_data_in  = max_new;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         left_ff      <= '0;
         max_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         left_ff      <= left_in;
         max_ff       <= max_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.peak_total = out_data_ff;
   assign ctl_o.shift        = accept;
   assign ctl_o.sum          = sum;
   assign row_o              = row_ff;

endmodule

[hdl/triangle_max_path_sum_unit.sv]
// ----------------------------------------------------------------------------
// triangle_max_path_sum_unit
// greatest top-to-bottom path sum of a streamed number triangle
// ----------------------------------------------------------------------------
// Entries arrive row by row, left to right, one transfer each; a new entry can
// be taken in every cycle, and the input stalls only while a finished result
// waits on a result channel that is not ready. The greatest path sum appears
// on the result channel in the cycle after the last entry of the last row. The
// previous row's sums travel down a chain of MAX_ROWS cells that all advance
// on each input transfer; each sum enters at the cell of its row index and
// reaches the head just when the entry below it is taken, so one add and
// compare per cycle sets the rate. csr_wr_data sets the row count (zero acts
// as one, values above MAX_ROWS act as MAX_ROWS); a change takes effect at
// once. Sums saturate at 65535.
// ----------------------------------------------------------------------------
module triangle_max_path_sum_unit #(
   parameter int MAX_ROWS = tmps_pkg::DEF_MAX_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   tmps_req_if.sink                         req_bus,
   tmps_rsp_if.source                       rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [tmps_pkg::ROW_COUNT_W-1:0] csr_wr_data
);
   import tmps_pkg::*;

   localparam int ROW_W = $clog2(MAX_ROWS);

   logic [ROW_COUNT_W-1:0] row_count_ff;
   chain_ctl_type          ctl;
   logic [ROW_W-1:0]       row;
   logic [SUM_W-1:0]       tap [MAX_ROWS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RESET;
      end else if (csr_wr_en) begin
         row_count_ff <= csr_wr_data;
      end
   end

   assign tap[MAX_ROWS] = '0;

   for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
      tmps_cell #(
         .IDX   (k),
         .ROW_W (ROW_W)
      ) u_cell (
         .clock  (clock),
         .ctl_i  (ctl),
         .row_i  (row),
         .next_i (tap[k+1]),
         .val_o  (tap[k])
      );
   end

   tmps_head #(
      .MAX_ROWS (MAX_ROWS),
      .ROW_W    (ROW_W)
   ) u_head (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .row_count_i (row_count_ff),
      .above_i     (tap[0]),
      .ctl_o       (ctl),
      .row_o       (row)
   );

endmodule

[hdl/tmps_check.sv]
// ----------------------------------------------------------------------------
// tmps_check
// port-level checks of the triangle path sum unit
// ----------------------------------------------------------------------------
module tmps_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [tmps_pkg::SUM_W-1:0] rsp_peak_total
);
   import tmps_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_peak_total))
      else $error("result dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without input transfer");

endmodule

bind triangle_max_path_sum_unit tmps_check u_tmps_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_peak_total (rsp_bus.peak_total)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the triangle path sum unit
// ----------------------------------------------------------------------------
// Triangles are streamed into the unit at random gaps while the result side
// stalls at random. A cycle-free model folds every accepted entry into its own
// copy of the best sums and queues the expected greatest totals, which are
// matched in order against the result transfers. The row count is rewritten
// between phases, at its limits too, and some phases stop inside a triangle
// so that a new row count lands on a partial triangle.
// ----------------------------------------------------------------------------
module tb_top;
   import tmps_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef enum int {FILL_UNIFORM, FILL_EXTREME, FILL_LOW, FILL_TOP} fill_kind_e;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [ROW_COUNT_W-1:0] csr_wr_data;

   tmps_req_if req_bus ();
   tmps_rsp_if rsp_bus ();

   triangle_max_path_sum_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // model state
   logic [SUM_W-1:0]       best_sum_above [DEF_MAX_ROWS];
   int unsigned            row_pos;
   int unsigned            col_pos;
   logic [SUM_W-1:0]       left_sum;
   logic [SUM_W-1:0]       row_peak;
   logic [ROW_COUNT_W-1:0] rows_cfg;

   logic [VALUE_W-1:0] entry_queue [$];
   logic [SUM_W-1:0]   expected_totals [$];

   logic        req_fire;
   int unsigned pushed_items;
   int unsigned accepted_items;
   int unsigned totals_checked;
   int unsigned mismatch_count;
   int unsigned stalled_cycles;
   int unsigned send_gap;
   int unsigned send_calm;
   int unsigned stall_left;
   int unsigned stall_calm;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic fill_kind_e pick_fill();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return FILL_UNIFORM;
      if (roll < 88) return FILL_EXTREME;
      if (roll < 94) return FILL_LOW;
      return FILL_TOP;
   endfunction

   function automatic int unsigned tri_len(input int unsigned rows);
      int unsigned eff;
      eff = (rows == 0) ? 1 : ((rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows);
      return eff * (eff + 1) / 2;
   endfunction

   // fold one entry into the best sums; queue a total at the end of a triangle
   task automatic fold_entry(input logic [VALUE_W-1:0] entry);
      int unsigned        r;
      int unsigned        c;
      int unsigned        rows;
      logic [SUM_W-1:0]   above;
      logic [SUM_W-1:0]   parent;
      logic [SUM_W-1:0]   sum;
      logic [SUM_W:0]     wide;
      rows = (rows_cfg == 0) ? 1 : ((rows_cfg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_cfg);
      r = (row_pos >= DEF_MAX_ROWS) ? DEF_MAX_ROWS - 1 : row_pos;
      c = (col_pos > r) ? r : col_pos;
      if (r == 0) begin
         sum = SUM_W'(entry);
      end else begin
         above = best_sum_above[c];
         if (c == 0) parent = above;
         else if (c == r) parent = left_sum;
         else parent = (left_sum > above) ? left_sum : above;
         left_sum = above;
         wide = {1'b0, parent} + (SUM_W + 1)'(entry);
         sum = (wide > {1'b0, SUM_MAX}) ? SUM_MAX : wide[SUM_W-1:0];
      end
      best_sum_above[c] = sum;
      if (c == 0 || sum > row_peak) row_peak = sum;
      if (c == r) begin
         if (r + 1 >= rows) begin
            expected_totals = {expected_totals, row_peak};
            row_pos = 0;
            row_peak = '0;
         end else begin
            row_pos = r + 1;
         end
         col_pos = 0;
         left_sum = '0;
      end else begin
         row_pos = r;
         col_pos = c + 1;
      end
   endtask

   task automatic push_value(input logic [VALUE_W-1:0] entry);
      entry_queue = {entry_queue, entry};
      pushed_items++;
   endtask

   task automatic push_entries(input int unsigned count, input fill_kind_e fill);
      logic [VALUE_W-1:0] entry;
      repeat (count) begin
         case (fill)
            FILL_EXTREME: entry = $urandom_range(0, 1) ? '1 : '0;
            FILL_LOW:     entry = VALUE_W'($urandom_range(0, 3));
            FILL_TOP:     entry = '1;
            default:      entry = VALUE_W'($urandom_range(0, 1023));
         endcase
         push_value(entry);
      end
   endtask

   // block idle: every item taken, every total seen, pipeline drained
   task automatic settle();
      do @(negedge clock);
      while (accepted_items != pushed_items || expected_totals.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_rows(input int unsigned rows);
      csr_wr_data <= ROW_COUNT_W'(rows);
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // stimulus
   initial begin
      int unsigned rand_base;
      int unsigned result_base;
      int unsigned roll;
      int unsigned rows_sel;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_bus.valid  = 1'b0;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;
      pushed_items   = 0;
      accepted_items = 0;
      totals_checked = 0;
      mismatch_count = 0;
      stalled_cycles = 0;
      send_gap       = 0;
      send_calm      = 0;
      stall_left     = 0;
      stall_calm     = 0;
      req_fire       = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // row count straight out of reset
      push_entries(tri_len(ROW_COUNT_RESET), FILL_UNIFORM);
      settle();

      write_rows(1);
      push_value('0);
      push_value('1);
      settle();
      write_rows(0);
      push_value(VALUE_W'(5));
      settle();
      write_rows(2);
      push_value('1);
      push_value('1);
      push_value('0);
      push_value('0);
      push_value('0);
      push_value('1);
      settle();
      // stop after two rows, then shrink the triangle under it
      write_rows(4);
      push_value(VALUE_W'(7));
      push_value(VALUE_W'(1));
      push_value(VALUE_W'(1000));
      settle();
      write_rows(2);
      push_value(VALUE_W'(3));
      push_value(VALUE_W'(2));
      push_value(VALUE_W'(1));
      settle();
      write_rows(3);
      for (int v = 1; v <= 6; v++) push_value(VALUE_W'(v));
      settle();

      // oversized row count, then a shrink that closes the triangle at the next row end
      write_rows(127);
      push_entries(tri_len(9), FILL_TOP);
      settle();
      write_rows(3);
      push_entries(10, FILL_TOP);
      settle();

      rand_base   = pushed_items;
      result_base = totals_checked;
      while (pushed_items - rand_base < 1100 || totals_checked - result_base < 40) begin
         roll = $urandom_range(0, 99);
         if (roll < 65) rows_sel = $urandom_range(1, 6);
         else if (roll < 85) rows_sel = $urandom_range(7, 16);
         else if (roll < 89) rows_sel = 0;
         else if (roll < 92) rows_sel = DEF_MAX_ROWS;
         else rows_sel = $urandom_range(17, 127);
         write_rows(rows_sel);
         if (rows_sel <= 16) begin
            repeat ($urandom_range(1, 4)) push_entries(tri_len(rows_sel), pick_fill());
         end
         if (rows_sel > 16 || $urandom_range(0, 3) == 0) begin
            push_entries($urandom_range(1, 40), pick_fill());
         end
         settle();
      end

      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expected_totals.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      logic               next_valid;
      logic [VALUE_W-1:0] next_value;
      next_valid = req_bus.valid;
      next_value = req_bus.value;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_fire) next_valid = 1'b0;
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (entry_queue.size() > 0) begin
               next_value = entry_queue.pop_front();
               next_valid = 1'b1;
               if (send_calm > 0) begin
                  send_calm--;
                  send_gap = 0;
               end else begin
                  send_gap = pick_gap();
                  if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(30, 150);
               end
            end
         end
      end
      req_bus.valid <= next_valid;
      req_bus.value <= next_value;
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (stall_calm > 0) begin
            stall_calm--;
         end else begin
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            if ($urandom_range(0, 99) < 2) stall_calm = $urandom_range(30, 150);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [SUM_W-1:0] want;
      if (reset) begin
         req_fire       <= 1'b0;
         row_pos        = 0;
         col_pos        = 0;
         left_sum       = '0;
         row_peak       = '0;
         rows_cfg       = ROW_COUNT_RESET;
         stalled_cycles = 0;
         foreach (best_sum_above[i]) best_sum_above[i] = '0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (csr_wr_en) rows_cfg = csr_wr_data;
         if (req_bus.valid && req_bus.ready) begin
            fold_entry(req_bus.value);
            accepted_items++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_totals.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("peak_total transfer %0d with nothing pending",
                           rsp_bus.peak_total);
               end
            end else begin
               want = expected_totals.pop_front();
               totals_checked++;
               if (rsp_bus.peak_total !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("peak_total mismatch: expected %0d, got %0d",
                              want, rsp_bus.peak_total);
                  end
               end
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
         end
      end
   end

   // watchdog
   initial begin
      do @(negedge clock);
      while (stalled_cycles < STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

endmodule
